FILE: rtl/core/sdjt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the spring-damper joint torque block.
// No dependencies; every other file in rtl/core imports this package.
package sdjt_pkg;

	// Number format of all data values.
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// Derived datapath widths.
	localparam int DISP_W     = DATA_WIDTH + 2;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int SPRING_W   = PROD_W + 2;
	localparam int TORQUE_W   = PROD_W + 3;
	localparam int DIV_STEPS  = PROD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// Register port layout.
	localparam int APB_DATA_W = (DATA_WIDTH > 32) ? 64 : 32;
	localparam int REG_SHIFT  = (DATA_WIDTH > 32) ? 3 : 2;
	localparam int REG_IDX_W  = 2;
	localparam int APB_ADDR_W = REG_SHIFT + REG_IDX_W;

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_ELASTICITY = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DAMPING    = 2'd2;

	// Operation codes of an input word.
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_RESET  = 1'b1;

	typedef logic [DATA_WIDTH-1:0] word_t;

	// Saturation limits of a data word.
	localparam word_t SMAX = word_t'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
	localparam word_t SMIN = word_t'(64'd1 << (DATA_WIDTH - 1));

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		word_t elasticity;
		word_t position_offset;
		word_t damping;
	} cfg_t;

endpackage

FILE: rtl/core/spring_damper_joint_torque.sv
`timescale 1ns / 1ps
// Spring-damper joint torque: sequencer, joint state and output register.
// Depends on sdjt_pkg, sdjt_regs, sdjt_mul and sdjt_div.
//
// Channel  Direction  Handshake                  Word
// item     in         item_valid / item_stall    op, measured_position, target_position,
//                                                time_step, rollback
// result   out        result_valid / result_stall torque, saturated
// config   in         psel / penable / pready    paddr, pwdata, prdata
//
// An update word passes S_PREP, S_MAG, S_MULA, S_MULB and S_MULC, waits
// in S_DIV on the one-bit-per-cycle divider over the 64-bit damping product
// if time_step is nonzero, then S_NEG and S_SUM. A reset word gives no result.
// After reset the stored position, held error and registers are zero.
// The block takes no new word until the current one is finished; a result
// waiting under result_stall holds the last step until the register frees.
module spring_damper_joint_torque (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sdjt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sdjt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sdjt_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            op,
	input  logic signed [sdjt_pkg::DATA_WIDTH-1:0] measured_position,
	input  logic signed [sdjt_pkg::DATA_WIDTH-1:0] target_position,
	input  logic [sdjt_pkg::DATA_WIDTH-1:0] time_step,
	input  logic                            rollback,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic signed [sdjt_pkg::DATA_WIDTH-1:0] torque,
	output logic                            saturated
);
	import sdjt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_MAG,
		S_MULA,
		S_MULB,
		S_MULC,
		S_DIV,
		S_NEG,
		S_SUM
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	// Captured input word.
	word_t                       meas_q;
	word_t                       tgt_q;
	word_t                       dt_q;
	logic                        rb_q;

	// Joint state.
	word_t                       prev_q;
	word_t                       held_q;

	// Intermediate values.
	word_t                       err_q;
	logic signed [DISP_W-1:0]    disp_q;
	logic [DATA_WIDTH:0]         disp_mag_q;
	word_t                       elas_mag_q;
	word_t                       err_mag_q;
	word_t                       damp_mag_q;
	logic                        spring_neg_q;
	logic                        damp_neg_q;
	logic [PROD_W:0]             spring_mag_q;
	logic signed [SPRING_W-1:0]  spring_q;
	logic signed [TORQUE_W-1:0]  damp_term_q;

	// Output register.
	logic                        result_valid_q;
	word_t                       torque_q;
	logic                        sat_q;

	// Combinational helpers.
	logic                        item_acc;
	logic                        res_free;
	logic                        dt_zero;
	logic signed [DATA_WIDTH:0]  diff_pm;
	word_t                       err_new;
	logic [DISP_W-1:0]           disp_abs;
	word_t                       mul_a;
	word_t                       mul_b;
	logic [PROD_W-1:0]           mul_p;
	logic [PROD_W-1:0]           div_quo;
	logic                        div_start;
	logic                        div_busy;
	logic                        div_done;
	logic [PROD_W-1:0]           quo_sel;
	logic signed [SPRING_W-1:0]  spring_sh;
	logic signed [TORQUE_W-1:0]  torque_full;
	logic [TORQUE_W-DATA_WIDTH:0] torque_top;
	logic                        in_range;
	word_t                       torque_sat;

	sdjt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	sdjt_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	sdjt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p),
		.divisor  (dt_q),
		.quotient (div_quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	// Handshakes.
	assign pready       = 1'b1;
	assign item_stall   = (state_q != S_IDLE);
	assign item_acc     = item_valid & ~item_stall;
	assign res_free     = ~result_valid_q | ~result_stall;
	assign result_valid = result_valid_q;
	assign torque       = torque_q;
	assign saturated    = sat_q;
	assign dt_zero      = (dt_q == '0);

	// Position error, saturated to the data range.
	assign diff_pm = $signed({prev_q[DATA_WIDTH-1], prev_q})
		- $signed({meas_q[DATA_WIDTH-1], meas_q});
	always_comb begin
		if (diff_pm[DATA_WIDTH] != diff_pm[DATA_WIDTH-1]) begin
			err_new = diff_pm[DATA_WIDTH] ? SMIN : SMAX;
		end else begin
			err_new = diff_pm[DATA_WIDTH-1:0];
		end
	end

	assign disp_abs = disp_q[DISP_W-1] ? DISP_W'(-disp_q) : DISP_W'(disp_q);

	// The multiplier serves the spring product first, then the damping product.
	assign mul_a = (state_q == S_MULA) ? disp_mag_q[DATA_WIDTH-1:0] : err_mag_q;
	assign mul_b = (state_q == S_MULA) ? elas_mag_q : damp_mag_q;

	assign div_start = (state_q == S_MULC) & ~dt_zero;
	assign quo_sel   = dt_zero ? '0 : div_quo;

	// Final sum and saturation.
	assign spring_sh   = spring_q >>> FRAC_BITS;
	assign torque_full = TORQUE_W'(spring_sh) + damp_term_q;
	assign torque_top  = torque_full[TORQUE_W-1:DATA_WIDTH-1];
	assign in_range    = (&torque_top) | ~(|torque_top);
	always_comb begin
		if (in_range) begin
			torque_sat = torque_full[DATA_WIDTH-1:0];
		end else begin
			torque_sat = torque_full[TORQUE_W-1] ? SMIN : SMAX;
		end
	end

	// Sequencer, joint state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			prev_q         <= '0;
			held_q         <= '0;
			result_valid_q <= 1'b0;
			torque_q       <= '0;
			sat_q          <= 1'b0;
		end else begin
			// The last step reloads the output register itself.
			if (result_valid_q && !result_stall && state_q != S_SUM) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (op == OP_RESET) begin
							prev_q <= measured_position;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					prev_q <= meas_q;
					if (!rb_q) begin
						held_q <= err_new;
					end
					state_q <= S_MAG;
				end
				S_MAG:  state_q <= S_MULA;
				S_MULA: state_q <= S_MULB;
				S_MULB: state_q <= S_MULC;
				S_MULC: state_q <= dt_zero ? S_NEG : S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_NEG;
					end
				end
				S_NEG:  state_q <= S_SUM;
				S_SUM: begin
					if (res_free) begin
						result_valid_q <= 1'b1;
						torque_q       <= torque_sat;
						sat_q          <= ~in_range;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded step by step under the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					meas_q <= measured_position;
					tgt_q  <= target_position;
					dt_q   <= time_step;
					rb_q   <= rollback;
				end
			end
			S_PREP: begin
				err_q  <= rb_q ? held_q : err_new;
				disp_q <= DISP_W'($signed(meas_q)) - DISP_W'($signed(tgt_q))
					+ DISP_W'($signed(cfg.position_offset));
			end
			S_MAG: begin
				disp_mag_q   <= disp_abs[DATA_WIDTH:0];
				elas_mag_q   <= cfg.elasticity[DATA_WIDTH-1] ? -cfg.elasticity
					: cfg.elasticity;
				damp_mag_q   <= cfg.damping[DATA_WIDTH-1] ? -cfg.damping : cfg.damping;
				err_mag_q    <= err_q[DATA_WIDTH-1] ? -err_q : err_q;
				spring_neg_q <= disp_q[DISP_W-1] ^ cfg.elasticity[DATA_WIDTH-1];
				damp_neg_q   <= err_q[DATA_WIDTH-1] ^ cfg.damping[DATA_WIDTH-1];
			end
			S_MULB: begin
				// Add the top displacement bit's share of the spring product.
				spring_mag_q <= {1'b0, mul_p}
					+ (disp_mag_q[DATA_WIDTH] ? {1'b0, elas_mag_q, {DATA_WIDTH{1'b0}}} : '0);
			end
			S_MULC: begin
				spring_q <= spring_neg_q ? -$signed({1'b0, spring_mag_q})
					: $signed({1'b0, spring_mag_q});
			end
			S_NEG: begin
				// The damping term is subtracted, so its sign flips here.
				damp_term_q <= damp_neg_q ? $signed(TORQUE_W'(quo_sel))
					: -$signed(TORQUE_W'(quo_sel));
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	// A clipped torque sits exactly at one of the two limits.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && sat_q |-> torque_q == SMAX || torque_q == SMIN)
		else $error("saturated torque is not at a limit");

	// A reset word gives no result and leaves the sequencer idle.
	a_reset_word: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && op == OP_RESET |=> state_q == S_IDLE && !$rose(result_valid_q))
		else $error("reset word started work or gave a result");

	// An update word starts the sequence.
	a_update_start: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && op == OP_UPDATE |=> state_q == S_PREP)
		else $error("update word did not start the sequence");

	// The divider finishes only while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the wait state");

	// The quotient is stable once the sign step reads it.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NEG |-> !div_busy)
		else $error("divider still busy when its quotient is used");
`endif

endmodule

FILE: rtl/core/sdjt_regs.sv
`timescale 1ns / 1ps
// Configuration register file with an APB-style write and read port.
// Depends on sdjt_pkg for the register layout and the cfg_t struct.
module sdjt_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sdjt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sdjt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sdjt_pkg::APB_DATA_W-1:0] prdata,
	output sdjt_pkg::cfg_t                  cfg
);
	import sdjt_pkg::*;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	cfg_t                 cfg_q;
	word_t                wdata;

	assign idx   = paddr[APB_ADDR_W-1:REG_SHIFT];
	assign wr_en = psel & penable & pwrite;
	assign wdata = pwdata[DATA_WIDTH-1:0];
	assign cfg   = cfg_q;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_ELASTICITY: cfg_q.elasticity      <= wdata;
				REG_OFFSET:     cfg_q.position_offset <= wdata;
				REG_DAMPING:    cfg_q.damping         <= wdata;
				default:        ;
			endcase
		end
	end

	// Read data follows the address; unmapped addresses read as zero.
	always_comb begin
		unique case (idx)
			REG_ELASTICITY: prdata = APB_DATA_W'(cfg_q.elasticity);
			REG_OFFSET:     prdata = APB_DATA_W'(cfg_q.position_offset);
			REG_DAMPING:    prdata = APB_DATA_W'(cfg_q.damping);
			default:        prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/sdjt_mul.sv
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on sdjt_pkg for the data and product widths.
module sdjt_mul (
	input  logic                        clk,
	input  sdjt_pkg::word_t             a,
	input  sdjt_pkg::word_t             b,
	output logic [sdjt_pkg::PROD_W-1:0] p_q
);
	import sdjt_pkg::*;

	// One full-width product per cycle, registered before use.
	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

FILE: rtl/core/sdjt_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on sdjt_pkg for the widths; the divisor must be nonzero.
module sdjt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sdjt_pkg::PROD_W-1:0] dividend,
	input  sdjt_pkg::word_t             divisor,
	output logic [sdjt_pkg::PROD_W-1:0] quotient,
	output logic                        busy,
	output logic                        done
);
	import sdjt_pkg::*;

	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] dvs_q;
	logic [PROD_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH+1:0] diff;
	logic                  fits;

	// Shift the next dividend bit into the remainder and try a subtract.
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign fits  = ~diff[DATA_WIDTH+1];

	assign quotient = quo_q;
	assign busy     = busy_q;
	assign done     = done_q;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient registers; the quotient shifts in over the dividend.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for spring_damper_joint_torque: drives gain writes and
// joint words, predicts each torque in fixed point and checks every result.
// Depends on sdjt_pkg and the spring_damper_joint_torque RTL only.
module tb;
	import sdjt_pkg::*;

	localparam int WIDE = 128;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES = 100;

	typedef struct {
		logic  op;
		word_t meas;
		word_t tgt;
		word_t dt;
		logic  rb;
	} joint_word_t;

	typedef struct {
		word_t torque;
		logic  sat;
	} torque_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	logic item_valid = 1'b0;
	logic item_stall;
	logic op = OP_UPDATE;
	word_t measured_position = '0;
	word_t target_position = '0;
	word_t time_step = '0;
	logic rollback = 1'b0;

	logic result_valid;
	logic result_stall = 1'b0;
	word_t torque;
	logic saturated;

	// Bench copy of the joint state and gain registers.
	word_t pos_prev = '0;
	word_t err_held = '0;
	word_t gain_spring = '0;
	word_t gain_offset = '0;
	word_t gain_damp = '0;

	joint_word_t joint_words[$];
	torque_exp_t torque_due[$];

	bit idle_on = 1'b1;
	int gap_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int fault_count = 0;
	int n_update = 0;
	int n_reset = 0;
	int n_rollback = 0;
	int n_sat = 0;
	int n_checked = 0;
	int n_phases = 0;

	spring_damper_joint_torque dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.measured_position(measured_position),
		.target_position(target_position),
		.time_step(time_step),
		.rollback(rollback),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.torque(torque),
		.saturated(saturated)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Sign-extend a data word to the wide working format.
	function automatic logic signed [WIDE-1:0] widen(input word_t v);
		return {{(WIDE - DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
	endfunction

	// Advance the joint state by one accepted word and queue the torque it gives.
	task automatic predict_joint(input joint_word_t w);
		logic signed [WIDE-1:0] err_x, disp_x, total_x, damp_x, e_s, d_s;
		logic [WIDE-1:0] prod_u, quo_u;
		logic [63:0] mag_e, mag_d;
		word_t err_w;
		torque_exp_t res;
		if (w.op == OP_RESET) begin
			pos_prev = w.meas;
		end else begin
			// Position error saturates before it is held or used.
			err_x = widen(pos_prev) - widen(w.meas);
			if (err_x > widen(SMAX))
				err_w = SMAX;
			else if (err_x < widen(SMIN))
				err_w = SMIN;
			else
				err_w = err_x[DATA_WIDTH-1:0];
			if (w.rb)
				err_w = err_held;
			else
				err_held = err_w;

			// Spring term: exact product, arithmetic shift rounds toward minus infinity.
			disp_x = widen(w.meas) - widen(w.tgt) + widen(gain_offset);
			total_x = (disp_x * widen(gain_spring)) >>> FRAC_BITS;

			// Damping term: magnitude quotient truncated toward zero, then signed.
			if (w.dt != '0) begin
				e_s = widen(err_w);
				d_s = widen(gain_damp);
				mag_e = (e_s < 0) ? -e_s : e_s;
				mag_d = (d_s < 0) ? -d_s : d_s;
				prod_u = mag_e * mag_d;
				quo_u = prod_u / {{(WIDE - DATA_WIDTH){1'b0}}, w.dt};
				damp_x = signed'(quo_u);
				if ((e_s < 0) != (d_s < 0))
					damp_x = -damp_x;
				total_x = total_x - damp_x;
			end

			res.sat = 1'b1;
			if (total_x > widen(SMAX))
				res.torque = SMAX;
			else if (total_x < widen(SMIN))
				res.torque = SMIN;
			else begin
				res.torque = total_x[DATA_WIDTH-1:0];
				res.sat = 1'b0;
			end
			torque_due.push_back(res);
			pos_prev = w.meas;
		end
	endtask

	// Word driver: presents queued joint words, with random gaps after a handoff.
	always @(posedge clk or negedge arst_n) begin
		logic fire;
		joint_word_t w;
		if (!arst_n) begin
			item_valid <= 1'b0;
			gap_left = 0;
		end else begin
			fire = item_valid && !item_stall;
			if (fire) begin
				w.op = op;
				w.meas = measured_position;
				w.tgt = target_position;
				w.dt = time_step;
				w.rb = rollback;
				predict_joint(w);
				if (op == OP_RESET)
					n_reset++;
				else
					n_update++;
				if (op == OP_UPDATE && rollback)
					n_rollback++;
			end
			if (!item_valid || fire) begin
				if (gap_left != 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (fire && idle_on && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 15);
					item_valid <= 1'b0;
				end else if (joint_words.size() != 0) begin
					w = joint_words.pop_front();
					op <= w.op;
					measured_position <= w.meas;
					target_position <= w.tgt;
					time_step <= w.dt;
					rollback <= w.rb;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: random stall bursts, and each torque word checked in order.
	always @(posedge clk or negedge arst_n) begin
		torque_exp_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (torque_due.size() == 0) begin
					$error("unexpected torque word %0d", torque);
					fault_count++;
				end else begin
					want = torque_due.pop_front();
					n_checked++;
					if (want.sat)
						n_sat++;
					if (torque !== want.torque) begin
						$error("torque: expected %0d, got %0d", $signed(want.torque), torque);
						fault_count++;
					end
					if (saturated !== want.sat) begin
						$error("saturated: expected %0b, got %0b", want.sat, saturated);
						fault_count++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (idle_on && !result_stall && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 15);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles with no handshake on any port.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// One APB transfer: setup cycle, then access until pready.
	task automatic apb_xfer(input logic [REG_IDX_W-1:0] idx, input bit wr, input word_t value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_ADDR_W'({idx, {REG_SHIFT{1'b0}}});
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr && prdata[DATA_WIDTH-1:0] !== value) begin
			$error("prdata: expected %h, got %h", value, prdata);
			fault_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Write all three gains, mirror them, and read them back.
	task automatic set_gains(input word_t spring, input word_t offset, input word_t damp);
		apb_xfer(REG_ELASTICITY, 1'b1, spring);
		apb_xfer(REG_OFFSET, 1'b1, offset);
		apb_xfer(REG_DAMPING, 1'b1, damp);
		gain_spring = spring;
		gain_offset = offset;
		gain_damp = damp;
		apb_xfer(REG_ELASTICITY, 1'b0, spring);
		apb_xfer(REG_OFFSET, 1'b0, offset);
		apb_xfer(REG_DAMPING, 1'b0, damp);
		n_phases++;
	endtask

	task automatic push_word(input logic o, input word_t m, input word_t t, input word_t d,
			input logic r);
		joint_word_t w;
		w.op = o;
		w.meas = m;
		w.tgt = t;
		w.dt = d;
		w.rb = r;
		joint_words.push_back(w);
	endtask

	// Wait until every word is taken and every torque has come back.
	task automatic drain();
		do @(negedge clk);
		while (joint_words.size() != 0 || item_valid || torque_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Positions: extremes, full range, or a small band around zero.
	function automatic word_t pick_pos();
		case ($urandom_range(0, 9))
			0: return SMAX;
			1: return SMIN;
			2: return '0;
			3, 4, 5: return word_t'($urandom);
			default: return word_t'($urandom_range(0, 32'h3FFFF) - 32'h20000);
		endcase
	endfunction

	// Time steps: zero disables damping, otherwise short, nominal or any.
	function automatic word_t pick_step();
		case ($urandom_range(0, 9))
			0, 1: return '0;
			2: return '1;
			3, 4: return word_t'($urandom_range(1, 32'h4000));
			5, 6, 7: return word_t'($urandom_range(1, 32'h40000));
			default: return word_t'($urandom);
		endcase
	endfunction

	// Gains: mostly moderate so results stay in range, sometimes anything.
	function automatic word_t pick_gain();
		case ($urandom_range(0, 7))
			0: return word_t'($urandom);
			1: return ($urandom_range(0, 1) != 0) ? SMAX : SMIN;
			2: return '0;
			default: return word_t'($urandom_range(0, 32'h7FFFF) - 32'h40000);
		endcase
	endfunction

	task automatic push_random(input int count);
		for (int i = 0; i < count; i++)
			push_word(($urandom_range(0, 9) == 0) ? OP_RESET : OP_UPDATE, pick_pos(), pick_pos(),
				pick_step(), $urandom_range(0, 4) == 0);
	endtask

	// Stimulus sequence.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Gains still at their reset value of zero.
		push_random(6);
		drain();

		// Odd gains to expose rounding, negative damping.
		set_gains(32'h0001_8001, 32'h0000_4000, 32'hFFFF_3001);
		push_word(OP_RESET, SMAX, '0, '0, 1'b1);
		push_word(OP_UPDATE, SMIN, '0, 32'd1, 1'b0);
		push_word(OP_RESET, SMIN, SMAX, '1, 1'b0);
		push_word(OP_UPDATE, SMAX, SMAX, '1, 1'b0);
		push_word(OP_UPDATE, 32'h0001_0000, '0, 32'd3, 1'b1);
		push_word(OP_UPDATE, '1, '0, '0, 1'b0);
		push_word(OP_UPDATE, 32'd1, '0, 32'd7, 1'b0);
		push_word(OP_UPDATE, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 1'b0);
		push_word(OP_UPDATE, 32'h0000_0400, '1, '0, 1'b1);
		push_word(OP_RESET, '0, '0, '0, 1'b0);
		push_word(OP_UPDATE, -32'sd5, 32'sd3, 32'd3, 1'b0);
		drain();

		// Extreme gains drive the torque into both rails.
		set_gains(SMAX, SMAX, SMIN);
		push_word(OP_UPDATE, SMAX, SMIN, 32'd1, 1'b0);
		push_word(OP_UPDATE, SMIN, SMAX, 32'd1, 1'b0);
		push_word(OP_UPDATE, '0, '0, '0, 1'b1);
		drain();

		set_gains(SMIN, SMIN, SMAX);
		push_word(OP_UPDATE, SMIN, SMAX, '1, 1'b0);
		push_word(OP_UPDATE, SMAX, SMIN, 32'd2, 1'b0);
		push_word(OP_RESET, 32'd12345, '0, '0, 1'b0);
		push_word(OP_UPDATE, 32'd12345, '0, 32'd1, 1'b0);
		drain();

		// Random phases, some without any idling.
		for (int ph = 0; ph < 10; ph++) begin
			set_gains(pick_gain(), pick_gain(), pick_gain());
			idle_on = (ph % 3 != 1);
			push_random(50);
			drain();
		end

		// Final stretch runs at full rate on both sides.
		idle_on = 1'b0;
		set_gains(32'h0002_0000, 32'hFFFF_8000, 32'h0000_C000);
		push_random(40);
		drain();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (torque_due.size() != 0) begin
			$error("%0d torque words never arrived", torque_due.size());
			fault_count++;
		end

		$display("Covered %0d update and %0d position-reset words (%0d rollbacks) over %0d gain settings.",
			n_update, n_reset, n_rollback, n_phases);
		$display("Checked %0d torque words, %0d of them clipped at a rail.", n_checked, n_sat);
		if (fault_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/sdjt_pkg.sv
rtl/core/sdjt_regs.sv
rtl/core/sdjt_mul.sv
rtl/core/sdjt_div.sv
rtl/core/spring_damper_joint_torque.sv
bench/tb.sv
